>>> hw/rtl/tsps_pkg.sv
// ----------------------------------------------------------------------------
// tsps_pkg
// Shared types, codes and constants of the shift positioner sequencer.
// ----------------------------------------------------------------------------
package tsps_pkg;

  // time counter width, all elapsed times wrap at this width
  localparam int TIME_BITS = 32;
  localparam int POS_BITS  = 32;
  localparam int MS_BITS   = 16;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  // stall and arrival thresholds
  localparam logic signed [POS_BITS:0] FAR_ERROR   = 33'sd5000;
  localparam logic signed [POS_BITS:0] NEAR_ERROR  = 33'sd3000;
  localparam logic signed [POS_BITS-1:0] STILL_SPEED = 32'sd5;

  // phase codes
  localparam logic [1:0] PHASE_IDLE      = 2'd0;
  localparam logic [1:0] PHASE_MOVING    = 2'd1;
  localparam logic [1:0] PHASE_HOLDING   = 2'd2;
  localparam logic [1:0] PHASE_RETURNING = 2'd3;

  // request codes
  localparam logic [1:0] REQ_IDLE    = 2'd0;
  localparam logic [1:0] REQ_FORWARD = 2'd1;
  localparam logic [1:0] REQ_REVERSE = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_POSITION = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_POSITION = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_POSITION  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_HOLD     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_HOLD     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_INTERVAL   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_WINDOW     = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOVE_TIMEOUT     = 3'd7;

  typedef struct packed {
    logic        [TIME_BITS-1:0] time_ms;
    logic        [1:0]           request;
    logic                        motor_ready;
    logic signed [POS_BITS-1:0]  measured_position;
    logic signed [POS_BITS-1:0]  measured_velocity;
  } tsps_item_t;

  typedef struct packed {
    logic                       send_command;
    logic signed [POS_BITS-1:0] command_position;
    logic        [1:0]          phase;
  } tsps_result_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] forward_position;
    logic signed [POS_BITS-1:0] reverse_position;
    logic signed [POS_BITS-1:0] origin_position;
    logic        [MS_BITS-1:0]  forward_hold_ms;
    logic        [MS_BITS-1:0]  reverse_hold_ms;
    logic        [MS_BITS-1:0]  retry_interval_ms;
    logic        [MS_BITS-1:0]  retry_window_ms;
    logic        [MS_BITS-1:0]  move_timeout_ms;
  } tsps_cfg_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [1:0]           last_request;
    logic [TIME_BITS-1:0] move_start_time;
    logic [TIME_BITS-1:0] last_send_time;
    logic [TIME_BITS-1:0] hold_start_time;
  } tsps_state_t;

endpackage

>>> hw/rtl/tsps_if.sv
// ----------------------------------------------------------------------------
// tsps_if
// Valid/ready channels for control ticks and sequencer results.
// ----------------------------------------------------------------------------
interface tsps_tick_if;
  logic                                        valid;
  logic                                        ready;
  logic        [tsps_pkg::TIME_BITS-1:0]       time_ms;
  logic        [1:0]                           request;
  logic                                        motor_ready;
  logic signed [tsps_pkg::POS_BITS-1:0]        measured_position;
  logic signed [tsps_pkg::POS_BITS-1:0]        measured_velocity;

  modport source (output valid, time_ms, request, motor_ready, measured_position,
                  measured_velocity, input ready);
  modport sink (input valid, time_ms, request, motor_ready, measured_position,
                measured_velocity, output ready);
endinterface

interface tsps_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 send_command;
  logic signed [tsps_pkg::POS_BITS-1:0] command_position;
  logic        [1:0]                    phase;

  modport source (output valid, send_command, command_position, phase, input ready);
  modport sink (input valid, send_command, command_position, phase, output ready);
endinterface

>>> hw/rtl/tsps_cfg.sv
// ----------------------------------------------------------------------------
// tsps_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tsps_cfg (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     wr_en,
  input  logic [tsps_pkg::CFG_INDEX_BITS-1:0]      wr_index,
  input  logic [tsps_pkg::CFG_DATA_BITS-1:0]       wr_data,
  output tsps_pkg::tsps_cfg_t                      cfg
);

  // register writes, reset loads the default set
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_position  <= '0;
      cfg.reverse_position  <= '0;
      cfg.origin_position   <= '0;
      cfg.forward_hold_ms   <= 16'd1000;
      cfg.reverse_hold_ms   <= 16'd1000;
      cfg.retry_interval_ms <= 16'd300;
      cfg.retry_window_ms   <= 16'd700;
      cfg.move_timeout_ms   <= 16'd1500;
    end else if (wr_en) begin
      unique case (wr_index)
        tsps_pkg::REG_FORWARD_POSITION: cfg.forward_position  <= wr_data;
        tsps_pkg::REG_REVERSE_POSITION: cfg.reverse_position  <= wr_data;
        tsps_pkg::REG_ORIGIN_POSITION:  cfg.origin_position   <= wr_data;
        tsps_pkg::REG_FORWARD_HOLD:     cfg.forward_hold_ms   <= wr_data[tsps_pkg::MS_BITS-1:0];
        tsps_pkg::REG_REVERSE_HOLD:     cfg.reverse_hold_ms   <= wr_data[tsps_pkg::MS_BITS-1:0];
        tsps_pkg::REG_RETRY_INTERVAL:   cfg.retry_interval_ms <= wr_data[tsps_pkg::MS_BITS-1:0];
        tsps_pkg::REG_RETRY_WINDOW:     cfg.retry_window_ms   <= wr_data[tsps_pkg::MS_BITS-1:0];
        tsps_pkg::REG_MOVE_TIMEOUT:     cfg.move_timeout_ms   <= wr_data[tsps_pkg::MS_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/tsps_step.sv
// ----------------------------------------------------------------------------
// tsps_step
// Single-tick sequencer update: phase transitions, retries and commands.
// ----------------------------------------------------------------------------
module tsps_step (
  input  tsps_pkg::tsps_item_t   item,
  input  tsps_pkg::tsps_state_t  state,
  input  tsps_pkg::tsps_cfg_t    cfg,
  output tsps_pkg::tsps_state_t  state_next,
  output tsps_pkg::tsps_result_t result
);

  logic [1:0]                             req;
  logic                                   new_req;
  logic signed [tsps_pkg::POS_BITS-1:0]   target;
  logic signed [tsps_pkg::POS_BITS:0]     pos_err;
  logic                                   far;
  logic                                   near;
  logic                                   still;
  logic [tsps_pkg::TIME_BITS-1:0]         since_send;
  logic [tsps_pkg::TIME_BITS-1:0]         since_move;
  logic [tsps_pkg::TIME_BITS-1:0]         since_hold;
  logic [tsps_pkg::MS_BITS-1:0]           hold_ms;
  tsps_pkg::tsps_state_t                  mid;
  logic                                   send;
  logic signed [tsps_pkg::POS_BITS-1:0]   cmd;

  // unused request code counts as idle
  assign req = (item.request == tsps_pkg::REQ_UNUSED) ? tsps_pkg::REQ_IDLE : item.request;
  assign new_req = (req != tsps_pkg::REQ_IDLE) && (req != state.last_request);

  // request handling comes first, the phase logic sees its outcome
  always_comb begin
    mid = state;
    if (new_req) begin
      mid.last_request    = req;
      mid.phase           = tsps_pkg::PHASE_MOVING;
      mid.move_start_time = item.time_ms;
      mid.last_send_time  = item.time_ms;
    end else if (req == tsps_pkg::REQ_IDLE) begin
      mid.last_request = tsps_pkg::REQ_IDLE;
    end
  end

  // target of the current move and the stall / arrival tests
  always_comb begin
    if (mid.phase == tsps_pkg::PHASE_RETURNING) begin
      target = cfg.origin_position;
    end else if (mid.last_request == tsps_pkg::REQ_FORWARD) begin
      target = cfg.forward_position;
    end else begin
      target = cfg.reverse_position;
    end
  end

  assign pos_err = {item.measured_position[tsps_pkg::POS_BITS-1], item.measured_position}
                 - {target[tsps_pkg::POS_BITS-1], target};
  assign far   = (pos_err > tsps_pkg::FAR_ERROR) || (pos_err < -tsps_pkg::FAR_ERROR);
  assign near  = (pos_err < tsps_pkg::NEAR_ERROR) && (pos_err > -tsps_pkg::NEAR_ERROR);
  assign still = (item.measured_velocity < tsps_pkg::STILL_SPEED)
              && (item.measured_velocity > -tsps_pkg::STILL_SPEED);

  // wrapping elapsed times
  assign since_send = item.time_ms - mid.last_send_time;
  assign since_move = item.time_ms - mid.move_start_time;
  assign since_hold = item.time_ms - mid.hold_start_time;
  assign hold_ms = (mid.last_request == tsps_pkg::REQ_FORWARD) ? cfg.forward_hold_ms
                                                               : cfg.reverse_hold_ms;

  // phase logic and command selection
  always_comb begin
    state_next = mid;
    send = new_req;
    cmd  = target;
    if (!item.motor_ready) begin
      state_next              = state;
      state_next.phase        = tsps_pkg::PHASE_IDLE;
      state_next.last_request = tsps_pkg::REQ_IDLE;
      send                    = 1'b0;
    end else begin
      unique case (mid.phase) inside
        tsps_pkg::PHASE_MOVING, tsps_pkg::PHASE_RETURNING: begin
          // stalled drive far from target gets the command again
          if (far && still
              && (since_send >= {{(tsps_pkg::TIME_BITS-tsps_pkg::MS_BITS){1'b0}},
                                 cfg.retry_interval_ms})
              && (since_move < {{(tsps_pkg::TIME_BITS-tsps_pkg::MS_BITS){1'b0}},
                                cfg.retry_window_ms})) begin
            state_next.last_send_time = item.time_ms;
            send = 1'b1;
          end
          if (near || (since_move >= {{(tsps_pkg::TIME_BITS-tsps_pkg::MS_BITS){1'b0}},
                                      cfg.move_timeout_ms})) begin
            if (mid.phase == tsps_pkg::PHASE_MOVING) begin
              state_next.phase           = tsps_pkg::PHASE_HOLDING;
              state_next.hold_start_time = item.time_ms;
            end else begin
              state_next.phase = tsps_pkg::PHASE_IDLE;
            end
          end
        end
        tsps_pkg::PHASE_HOLDING: begin
          // hold over, command the origin
          if (since_hold >= {{(tsps_pkg::TIME_BITS-tsps_pkg::MS_BITS){1'b0}}, hold_ms}) begin
            state_next.phase           = tsps_pkg::PHASE_RETURNING;
            state_next.move_start_time = item.time_ms;
            state_next.last_send_time  = item.time_ms;
            send = 1'b1;
            cmd  = cfg.origin_position;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.send_command     = send;
  assign result.command_position = send ? cmd : '0;
  assign result.phase            = state_next.phase;

endmodule

>>> hw/rtl/timed_shift_positioner_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_shift_positioner_sequencer_unit
// Move / hold / return sequencer for a position-controlled shift drive.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one control tick per transaction (time, request, drive status,
//            measured position and velocity), valid/ready handshake
//   result : one transaction per tick (send_command, command_position, phase)
//   wr_en / wr_index / wr_data : register writes, only while the block is idle
// Path: an accepted tick is captured in the input register; its result is
//   loaded into the result register once that register is free or being
//   drained, and is offered from then on.
// Throughput: one tick per cycle while result.ready is high; the update is
//   one pass of compare and subtract logic between the input register and
//   the result register, the sequencer state written back in the same cycle.
// Stall: when the result receiver holds ready low, the result waits in its
//   register, one more tick waits in the input register, and tick.ready drops
//   only once both are full.
// Reset: rst (synchronous) empties both registers, puts the sequencer in idle
//   and reloads the register defaults.
// ----------------------------------------------------------------------------
module timed_shift_positioner_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst,
  tsps_tick_if.sink                           tick,
  tsps_result_if.source                       result,
  input  logic                                wr_en,
  input  logic [tsps_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [tsps_pkg::CFG_DATA_BITS-1:0]  wr_data
);

  tsps_pkg::tsps_cfg_t    cfg;
  tsps_pkg::tsps_state_t  state;
  tsps_pkg::tsps_state_t  state_next;
  tsps_pkg::tsps_item_t   item;
  tsps_pkg::tsps_result_t step_result;
  tsps_pkg::tsps_result_t res;
  logic                   item_valid;
  logic                   res_valid;
  logic                   advance;

  // configuration registers
  tsps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // the input item moves on when the result register is free or being drained
  assign advance    = item_valid && (!res_valid || result.ready);
  assign tick.ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (tick.ready) begin
      item_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      item.time_ms           <= tick.time_ms;
      item.request           <= tick.request;
      item.motor_ready       <= tick.motor_ready;
      item.measured_position <= tick.measured_position;
      item.measured_velocity <= tick.measured_velocity;
    end
  end

  // sequencer update
  tsps_step u_step (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (step_result)
  );

  // sequencer state, written once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  assign result.valid            = res_valid;
  assign result.send_command     = res.send_command;
  assign result.command_position = res.command_position;
  assign result.phase            = res.phase;

  // no command position is shown without a command
  a_quiet_position: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.send_command) |-> (result.command_position == '0))
    else $error("command position nonzero without send_command");

  // a drive that is not ready leaves the sequencer idle
  a_not_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && !item.motor_ready) |=> (state.phase == tsps_pkg::PHASE_IDLE))
    else $error("sequencer not idle after drive not ready");

  // a waiting tick is neither lost nor altered
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> (item_valid && $stable(item)))
    else $error("waiting tick lost or changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

>>> bench/timed_shift_positioner_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_shift_positioner_sequencer_unit_tb
// Self-checking bench for the move / hold / return sequencer. A short table
// of directed ticks comes first, then random sequences of ticks under several
// register settings. Every tick is run through a local model of the sequencer,
// and every result transaction is compared field by field in arrival order.
// Both channels are throttled: bursty ticks and a patterned result stall.
// ----------------------------------------------------------------------------
module timed_shift_positioner_sequencer_unit_tb;
  import tsps_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 141;
  localparam int LONG_STALL      = 80;
  localparam int SETTLE_CYCLES   = 10;
  localparam int CYCLE_LIMIT     = 200000;

  // one row of the directed table: a register write or a tick
  typedef struct {
    bit                        wr;
    logic [CFG_INDEX_BITS-1:0] wr_idx;
    logic [CFG_DATA_BITS-1:0]  wr_val;
    tsps_item_t                tick;
    bit                        typed;
    tsps_result_t              want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  tsps_tick_if   tick_ch ();
  tsps_result_if result_ch ();

  timed_shift_positioner_sequencer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // model of the sequencer: registers and state
  tsps_cfg_t    seq_cfg;
  tsps_state_t  seq;
  tsps_result_t expected_q[$];
  stim_row_t    stim_rows[$];

  int          error_count    = 0;
  int          tick_count     = 0;
  int          directed_count = 0;
  int          checked_count  = 0;
  int          command_count  = 0;
  int          settings_count = 0;
  int          burst_left     = 0;
  int unsigned cycle_count    = 0;
  logic [3:0]  phases_seen    = '0;

  // result stall pattern and the long hold-off
  logic        stall_req    = 1'b0;
  logic        stall_active = 1'b0;
  int          sink_mode    = 0;
  int          sink_left    = 0;
  int unsigned sink_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // one control tick through the sequencer model, returns the expected result
  function automatic tsps_result_t step_sequencer(input tsps_item_t it);
    tsps_result_t               r;
    logic [1:0]                 req;
    logic signed [POS_BITS-1:0] target;
    logic [TIME_BITS-1:0]       since_send;
    logic [TIME_BITS-1:0]       since_start;
    logic [TIME_BITS-1:0]       since_hold;
    logic [MS_BITS-1:0]         hold;
    longint                     err;
    longint                     speed;
    r = '0;
    req = (it.request == REQ_UNUSED) ? REQ_IDLE : it.request;
    if (!it.motor_ready) begin
      seq.phase = PHASE_IDLE;
      seq.last_request = REQ_IDLE;
    end else begin
      // new nonzero request starts a move
      if (req != REQ_IDLE && req != seq.last_request) begin
        seq.last_request = req;
        r.send_command = 1'b1;
        r.command_position = (req == REQ_FORWARD) ? seq_cfg.forward_position :
                                                    seq_cfg.reverse_position;
        seq.phase = PHASE_MOVING;
        seq.move_start_time = it.time_ms;
        seq.last_send_time = it.time_ms;
      end else if (req == REQ_IDLE) begin
        seq.last_request = REQ_IDLE;
      end

      if (seq.phase == PHASE_MOVING || seq.phase == PHASE_RETURNING) begin
        if (seq.phase == PHASE_RETURNING) target = seq_cfg.origin_position;
        else if (seq.last_request == REQ_FORWARD) target = seq_cfg.forward_position;
        else target = seq_cfg.reverse_position;
        err = longint'($signed(it.measured_position)) - longint'(target);
        if (err < 0) err = -err;
        speed = longint'($signed(it.measured_velocity));
        if (speed < 0) speed = -speed;
        since_send = it.time_ms - seq.last_send_time;
        since_start = it.time_ms - seq.move_start_time;
        // stalled far from target: command again, only inside the retry window
        if (err > longint'(FAR_ERROR) && speed < longint'(STILL_SPEED) &&
            since_send >= seq_cfg.retry_interval_ms &&
            since_start < seq_cfg.retry_window_ms) begin
          seq.last_send_time = it.time_ms;
          r.send_command = 1'b1;
          r.command_position = target;
        end
        // arrival or timeout ends the move
        if (err < longint'(NEAR_ERROR) || since_start >= seq_cfg.move_timeout_ms) begin
          if (seq.phase == PHASE_MOVING) begin
            seq.phase = PHASE_HOLDING;
            seq.hold_start_time = it.time_ms;
          end else begin
            seq.phase = PHASE_IDLE;
          end
        end
      end else if (seq.phase == PHASE_HOLDING) begin
        hold = (seq.last_request == REQ_FORWARD) ? seq_cfg.forward_hold_ms :
                                                   seq_cfg.reverse_hold_ms;
        since_hold = it.time_ms - seq.hold_start_time;
        // hold over: head back to the origin
        if (since_hold >= hold) begin
          r.send_command = 1'b1;
          r.command_position = seq_cfg.origin_position;
          seq.phase = PHASE_RETURNING;
          seq.move_start_time = it.time_ms;
          seq.last_send_time = it.time_ms;
        end
      end
    end
    r.phase = seq.phase;
    return r;
  endfunction

  // result side: check each transaction, then pick the next ready value
  always @(posedge clk) begin : result_sink
    tsps_result_t want;
    logic         take;
    if (!rst && result_ch.valid && result_ch.ready) begin
      checked_count++;
      phases_seen[result_ch.phase] = 1'b1;
      if (result_ch.send_command) command_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with no tick pending",
                        result_ch.command_position, '0);
      end else begin
        want = expected_q.pop_front();
        if (result_ch.send_command !== want.send_command)
          report_mismatch("send_command", 32'(result_ch.send_command),
                          32'(want.send_command));
        if (result_ch.command_position !== want.command_position)
          report_mismatch("command_position", result_ch.command_position,
                          want.command_position);
        if (result_ch.phase !== want.phase)
          report_mismatch("phase", 32'(result_ch.phase), 32'(want.phase));
      end
    end

    // stall pattern changes mode every so often
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(10, 150);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0:       take = 1'b1;
      1:       take = 1'($urandom_range(0, 1));
      2:       take = (sink_count[1:0] == 2'd0);
      default: take = ($urandom_range(0, 9) != 0);
    endcase
    sink_count <= sink_count + 1;
    result_ch.ready <= stall_active ? 1'b0 : take;
  end

  // long receiver hold-off, started once by the stimulus
  initial begin : long_hold_off
    wait (stall_req);
    @(posedge clk);
    stall_active <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    stall_active <= 1'b0;
  end

  // offer one tick and wait until it is accepted
  task automatic offer_tick(input tsps_item_t it, input bit typed,
                            input tsps_result_t want);
    tsps_result_t pred;
    tick_ch.valid             <= 1'b1;
    tick_ch.time_ms           <= it.time_ms;
    tick_ch.request           <= it.request;
    tick_ch.motor_ready       <= it.motor_ready;
    tick_ch.measured_position <= it.measured_position;
    tick_ch.measured_velocity <= it.measured_velocity;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    pred = step_sequencer(it);
    expected_q.push_back(typed ? want : pred);
    tick_count++;
  endtask

  // bursts of ticks with random gaps in between
  task automatic pace_sender(input bit gaps_on);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // stop offering until every pending result has come back
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      REG_FORWARD_POSITION: seq_cfg.forward_position  = val;
      REG_REVERSE_POSITION: seq_cfg.reverse_position  = val;
      REG_ORIGIN_POSITION:  seq_cfg.origin_position   = val;
      REG_FORWARD_HOLD:     seq_cfg.forward_hold_ms   = val[MS_BITS-1:0];
      REG_REVERSE_HOLD:     seq_cfg.reverse_hold_ms   = val[MS_BITS-1:0];
      REG_RETRY_INTERVAL:   seq_cfg.retry_interval_ms = val[MS_BITS-1:0];
      REG_RETRY_WINDOW:     seq_cfg.retry_window_ms   = val[MS_BITS-1:0];
      default:              seq_cfg.move_timeout_ms   = val[MS_BITS-1:0];
    endcase
  endtask

  // full register set, written once the block has gone quiet
  task automatic load_settings(input tsps_cfg_t c);
    drain_results();
    apply_reg(REG_FORWARD_POSITION, c.forward_position);
    apply_reg(REG_REVERSE_POSITION, c.reverse_position);
    apply_reg(REG_ORIGIN_POSITION,  c.origin_position);
    apply_reg(REG_FORWARD_HOLD,     {16'd0, c.forward_hold_ms});
    apply_reg(REG_REVERSE_HOLD,     {16'd0, c.reverse_hold_ms});
    apply_reg(REG_RETRY_INTERVAL,   {16'd0, c.retry_interval_ms});
    apply_reg(REG_RETRY_WINDOW,     {16'd0, c.retry_window_ms});
    apply_reg(REG_MOVE_TIMEOUT,     {16'd0, c.move_timeout_ms});
    wr_en <= 1'b0;
    settings_count++;
  endtask

  task automatic add_tick(input logic [31:0] t_ms, input logic [1:0] req,
                          input logic rdy, input logic [31:0] pos,
                          input logic [31:0] vel);
    stim_row_t row;
    row = '{wr: 1'b0, wr_idx: '0, wr_val: '0, tick: '0, typed: 1'b0, want: '0};
    row.tick.time_ms           = t_ms;
    row.tick.request           = req;
    row.tick.motor_ready       = rdy;
    row.tick.measured_position = pos;
    row.tick.measured_velocity = vel;
    stim_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [31:0] t_ms, input logic [1:0] req,
                           input logic rdy, input logic [31:0] pos,
                           input logic [31:0] vel, input logic snd,
                           input logic [31:0] cmd, input logic [1:0] ph);
    add_tick(t_ms, req, rdy, pos, vel);
    stim_rows[$].typed = 1'b1;
    stim_rows[$].want.send_command = snd;
    stim_rows[$].want.command_position = cmd;
    stim_rows[$].want.phase = ph;
  endtask

  task automatic add_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    stim_row_t row;
    row = '{wr: 1'b1, wr_idx: idx, wr_val: val, tick: '0, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endtask

  initial begin : stimulus
    tsps_cfg_t                  c;
    tsps_item_t                 it;
    logic [1:0]                 held_req;
    logic signed [POS_BITS-1:0] aim;
    logic [31:0]                offs;
    logic [31:0]                now;
    int                         step_max;
    int                         pick;
    bit                         gaps_on;

    rst                         <= 1'b1;
    wr_en                       <= 1'b0;
    wr_index                    <= '0;
    wr_data                     <= '0;
    tick_ch.valid               <= 1'b0;
    tick_ch.time_ms             <= '0;
    tick_ch.request             <= REQ_IDLE;
    tick_ch.motor_ready         <= 1'b0;
    tick_ch.measured_position   <= '0;
    tick_ch.measured_velocity   <= '0;

    // model starts from the reset values
    seq = '0;
    seq.phase = PHASE_IDLE;
    seq.last_request = REQ_IDLE;
    seq_cfg = '0;
    seq_cfg.forward_hold_ms   = 16'd1000;
    seq_cfg.reverse_hold_ms   = 16'd1000;
    seq_cfg.retry_interval_ms = 16'd300;
    seq_cfg.retry_window_ms   = 16'd700;
    seq_cfg.move_timeout_ms   = 16'd1500;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first tick straight out of reset with the drive not ready
    add_typed(32'd0, REQ_FORWARD, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0, PHASE_IDLE);
    offer_tick(stim_rows[0].tick, stim_rows[0].typed, stim_rows[0].want);
    directed_count++;
    stim_rows.delete();

    // directed settings: short times so each step of a move is visible
    c.forward_position  = 32'sd100000;
    c.reverse_position  = -32'sd100000;
    c.origin_position   = 32'sd0;
    c.forward_hold_ms   = 16'd50;
    c.reverse_hold_ms   = 16'd80;
    c.retry_interval_ms = 16'd10;
    c.retry_window_ms   = 16'd40;
    c.move_timeout_ms   = 16'd100;
    load_settings(c);

    // forward move with a retry, window closing, arrival, hold, timed-out return
    add_typed(32'd1000, REQ_FORWARD, 1'b1, 32'd0, 32'd0, 1'b1, 32'sd100000, PHASE_MOVING);
    add_tick(32'd1005, REQ_FORWARD, 1'b1, 32'd0, 32'd0);
    add_tick(32'd1010, REQ_FORWARD, 1'b1, 32'd0, 32'd0);
    add_tick(32'd1020, REQ_FORWARD, 1'b1, 32'd0, 32'd1000);
    add_tick(32'd1045, REQ_FORWARD, 1'b1, 32'd0, 32'd0);
    add_tick(32'd1050, REQ_FORWARD, 1'b1, 32'd98000, 32'd0);
    add_tick(32'd1099, REQ_FORWARD, 1'b1, 32'd98000, 32'd0);
    add_tick(32'd1100, REQ_FORWARD, 1'b1, 32'd98000, 32'd0);
    add_tick(32'd1101, REQ_FORWARD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_tick(32'd1200, REQ_FORWARD, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // reverse move across the time wrap, released while moving
    add_typed(32'hFFFF_FFFF, REQ_REVERSE, 1'b1, 32'h8000_0000, 32'd4,
              1'b1, -32'sd100000, PHASE_MOVING);
    add_tick(32'h0000_000A, REQ_REVERSE, 1'b1, 32'h8000_0000, -32'sd4);
    add_tick(32'h0000_0010, REQ_IDLE, 1'b1, -32'sd100000, 32'd0);
    add_tick(32'h0000_005F, REQ_UNUSED, 1'b1, -32'sd100000, 32'd0);
    add_tick(32'h0000_0060, REQ_IDLE, 1'b1, -32'sd100000, 32'd0);
    // new request during the return, arriving at once
    add_tick(32'h0000_0061, REQ_FORWARD, 1'b1, 32'sd100000, 32'd0);
    add_typed(32'h0000_0062, REQ_FORWARD, 1'b0, 32'sd100000, 32'd0,
              1'b0, 32'd0, PHASE_IDLE);
    // zero retry interval: new request and retry in the same tick
    add_write(REG_RETRY_INTERVAL, 32'd0);
    add_tick(32'd5000, REQ_FORWARD, 1'b1, 32'd0, 32'd0);
    add_tick(32'd5001, REQ_FORWARD, 1'b1, 32'd0, 32'd0);
    add_tick(32'd5002, REQ_REVERSE, 1'b1, 32'd0, 32'd0);
    add_typed(32'd5100, REQ_FORWARD, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0, PHASE_IDLE);

    // walk the table
    foreach (stim_rows[k]) begin
      if (stim_rows[k].wr) begin
        if (k == 0 || !stim_rows[k-1].wr) drain_results();
        apply_reg(stim_rows[k].wr_idx, stim_rows[k].wr_val);
        if (k == stim_rows.size() - 1 || !stim_rows[k+1].wr) wr_en <= 1'b0;
      end else begin
        pace_sender(1'b1);
        offer_tick(stim_rows[k].tick, stim_rows[k].typed, stim_rows[k].want);
        directed_count++;
      end
    end

    // random sequences under changing settings
    held_req = REQ_IDLE;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          // all times zero, extreme targets
          c = '0;
          c.forward_position = 32'h7FFF_FFFF;
          c.reverse_position = 32'h8000_0000;
          c.origin_position  = 32'd0;
        end
        1: begin
          // all times at their maximum
          c.forward_position  = $urandom;
          c.reverse_position  = $urandom;
          c.origin_position   = $urandom;
          c.forward_hold_ms   = 16'hFFFF;
          c.reverse_hold_ms   = 16'hFFFF;
          c.retry_interval_ms = 16'hFFFF;
          c.retry_window_ms   = 16'hFFFF;
          c.move_timeout_ms   = 16'hFFFF;
        end
        RANDOM_PHASES - 1: begin
          // reset default times
          c.forward_position  = $urandom;
          c.reverse_position  = $urandom;
          c.origin_position   = $urandom;
          c.forward_hold_ms   = 16'd1000;
          c.reverse_hold_ms   = 16'd1000;
          c.retry_interval_ms = 16'd300;
          c.retry_window_ms   = 16'd700;
          c.move_timeout_ms   = 16'd1500;
        end
        default: begin
          c.forward_position  = $urandom;
          c.reverse_position  = $urandom;
          c.origin_position   = $urandom_range(0, 1) ? 32'd0 : $urandom;
          c.forward_hold_ms   = 16'($urandom_range(0, 60));
          c.reverse_hold_ms   = 16'($urandom_range(0, 60));
          c.retry_interval_ms = 16'($urandom_range(0, 20));
          c.retry_window_ms   = 16'($urandom_range(0, 80));
          c.move_timeout_ms   = 16'($urandom_range(0, 150));
        end
      endcase
      load_settings(c);

      step_max = (p == 1) ? 20000 : int'(c.move_timeout_ms) / 6 + 3;
      now = (p % 2 == 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 500);
      gaps_on = !(p == 2 || p == 3);

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // receiver blocks for a long stretch while ticks keep coming
        if (p == 2 && n == 20) stall_req = 1'b1;
        // sender waits once until everything has come back
        if (p == 4 && n == 70) drain_results();

        if ($urandom_range(0, 99) < 6) held_req = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 90) now = now + $urandom_range(0, step_max);
        else if (pick < 93) now = $urandom;
        it.time_ms     = now;
        it.request     = held_req;
        it.motor_ready = ($urandom_range(0, 99) >= 3);

        // aim positions at whatever the block is driving toward
        if (seq.phase == PHASE_RETURNING) aim = seq_cfg.origin_position;
        else if (seq.last_request == REQ_FORWARD) aim = seq_cfg.forward_position;
        else if (seq.last_request == REQ_REVERSE) aim = seq_cfg.reverse_position;
        else if (held_req == REQ_FORWARD) aim = seq_cfg.forward_position;
        else aim = seq_cfg.reverse_position;

        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it.measured_position = aim + $urandom_range(0, 5000) - 32'd2500;
        end else if (pick < 50) begin
          // right at the arrival and stall thresholds
          offs = ($urandom_range(0, 1) ? 32'd3000 : 32'd5000) + $urandom_range(0, 2) - 32'd1;
          it.measured_position = $urandom_range(0, 1) ? aim + offs : aim - offs;
        end else if (pick < 80) begin
          offs = $urandom_range(5001, 200000);
          it.measured_position = $urandom_range(0, 1) ? aim + offs : aim - offs;
        end else begin
          it.measured_position = $urandom;
        end

        pick = $urandom_range(0, 99);
        if (pick < 60) it.measured_velocity = $urandom_range(0, 12) - 32'd6;
        else if (pick < 85) it.measured_velocity = $urandom_range(0, 2000) - 32'd1000;
        else if (pick < 95) it.measured_velocity = $urandom;
        else it.measured_velocity = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;

        pace_sender(gaps_on);
        offer_tick(it, 1'b0, '0);
      end
    end

    // let the last results come back
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d ticks (%0d directed), %0d results checked, %0d commands sent",
             tick_count, directed_count, checked_count, command_count);
    $display("summary: %0d register settings, phases reached %b, %0d mismatches",
             settings_count, phases_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tsps_pkg.sv
hw/rtl/tsps_if.sv
hw/rtl/tsps_cfg.sv
hw/rtl/tsps_step.sv
hw/rtl/timed_shift_positioner_sequencer_unit.sv
bench/timed_shift_positioner_sequencer_unit_tb.sv
